@@ rtl/pau3x_pkg.sv @@
// Package for the 3x pixel-art upscaler: beat types, queue status and constants.
package pau3x_pkg;

  localparam int unsigned PORT_PIX_W         = 32;
  localparam int unsigned PIXEL_BITS_DEFAULT = 32;
  localparam int unsigned QUEUE_DEPTH        = 4;

  typedef struct packed {
    logic [PORT_PIX_W-1:0] pix_above;
    logic [PORT_PIX_W-1:0] pix_center;
    logic [PORT_PIX_W-1:0] pix_below;
    logic                  end_of_row;
  } in_beat_t;

  typedef struct packed {
    logic [PORT_PIX_W-1:0] top_left;
    logic [PORT_PIX_W-1:0] top_mid;
    logic [PORT_PIX_W-1:0] top_right;
    logic [PORT_PIX_W-1:0] mid_left;
    logic [PORT_PIX_W-1:0] mid_mid;
    logic [PORT_PIX_W-1:0] mid_right;
    logic [PORT_PIX_W-1:0] bot_left;
    logic [PORT_PIX_W-1:0] bot_mid;
    logic [PORT_PIX_W-1:0] bot_right;
    logic                  last_of_row;
  } out_beat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/pixel_art_upscale_3x.sv @@
// Top level of the 3x pixel-art upscaler (scale3x, early variant).
// Input channel: one beat per source column (pixel above, center, below and an
// end-of-row mark), handshake in_valid_i / in_stall_o.
// Output channel: one beat per 3x3 output block, out_valid_o / out_stall_i;
// last_of_row marks the block of a row's final column.
// A column's block is issued when the next column arrives, or at once when the
// column carries the end-of-row mark. Block beats pass through the job queue and
// the output register; the second block of an end-of-row pair waits first in
// a pending register of the front end.
// Throughput: one column per cycle unless the queue is full; an end-of-row beat
// that also completes the preceding column yields two blocks and stalls the input
// while the second is pending, since the four-entry job queue has one write port.
// Reset empties the queue and the output register and starts a new row; no
// clearing pass is needed.
// When the receiver stalls, the output register holds its block, the queue
// fills and the input stalls once four jobs wait.
// Pixels are PIXEL_BITS wide; higher input bits are ignored and higher output
// bits read as zero.
module pixel_art_upscale_3x import pau3x_pkg::*; #(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_o
);

  localparam int unsigned JobW = 5 * PIXEL_BITS + 1;

  q_stat_t         q_stat;
  logic            push, pop;
  logic [JobW-1:0] push_job, head_job;

  pau3x_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_job_o (push_job)
  );

  pau3x_queue #(.PIXEL_BITS(PIXEL_BITS)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_job_o (head_job),
    .q_stat_o   (q_stat)
  );

  pau3x_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_job_i  (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  a_mid_row_is_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.mid_left == out_o.mid_mid && out_o.mid_right == out_o.mid_mid &&
                     out_o.top_mid == out_o.mid_mid && out_o.bot_mid == out_o.mid_mid))
    else $error("middle pixels of block differ from center");

  a_full_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> in_stall_o)
    else $error("input not stalled while job queue full");

  a_push_not_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.full && !pop) |=> !(q_stat.empty))
    else $error("job queue drained without pop");

  a_high_bits_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_o.top_left >> PIXEL_BITS) == '0 &&
                     (out_o.bot_right >> PIXEL_BITS) == '0))
    else $error("output bits above pixel width set");

endmodule

@@ rtl/pau3x_front.sv @@
// Front end: accepts column beats, tracks row neighbors and issues block jobs.
module pau3x_front import pau3x_pkg::*; #(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEFAULT,
  localparam int unsigned JobW      = 5 * PIXEL_BITS + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_beat_t        in_i,
  input  q_stat_t         q_stat_i,
  output logic            push_o,
  output logic [JobW-1:0] push_job_o
);

  logic [PIXEL_BITS-1:0] left_c_q, held_a_q, held_c_q, held_b_q;
  logic                  held_q, held_d;
  logic                  row_start_q, row_start_d;
  logic                  pend_q, pend_d;
  logic [JobW-1:0]       pend_job_q;
  logic [PIXEL_BITS-1:0] a, c, b;
  logic                  eor, acc;
  logic [JobW-1:0]       job_held, job_eor;

  assign a   = in_i.pix_above[PIXEL_BITS-1:0];
  assign c   = in_i.pix_center[PIXEL_BITS-1:0];
  assign b   = in_i.pix_below[PIXEL_BITS-1:0];
  assign eor = in_i.end_of_row;

  assign in_stall_o = pend_q | q_stat_i.full;
  assign acc        = in_valid_i & ~in_stall_o;

  // job layout: {last, f, d, h, e, b}
  assign job_held = {1'b0, c, (row_start_q ? held_c_q : left_c_q), held_b_q, held_c_q, held_a_q};
  assign job_eor  = {1'b1, c, (held_q ? held_c_q : c), b, c, a};

  always_comb begin
    push_o      = 1'b0;
    push_job_o  = held_q ? job_held : job_eor;
    pend_d      = pend_q;
    held_d      = held_q;
    row_start_d = row_start_q;
    if (pend_q) begin
      push_o     = ~q_stat_i.full;
      push_job_o = pend_job_q;
      if (!q_stat_i.full) begin
        pend_d = 1'b0;
      end
    end else if (acc) begin
      push_o      = held_q | eor;
      pend_d      = held_q & eor;
      held_d      = ~eor;
      row_start_d = eor | (row_start_q & ~held_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      row_start_q <= 1'b1;
      pend_q      <= 1'b0;
    end else begin
      held_q      <= held_d;
      row_start_q <= row_start_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      held_a_q <= a;
      held_c_q <= c;
      held_b_q <= b;
      if (held_q) begin
        left_c_q <= held_c_q;
      end
      if (held_q && eor) begin
        pend_job_q <= job_eor;
      end
    end
  end

endmodule

@@ rtl/pau3x_queue.sv @@
// Job queue between the front end and the block generator.
module pau3x_queue import pau3x_pkg::*; #(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEFAULT,
  localparam int unsigned JobW      = 5 * PIXEL_BITS + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [JobW-1:0] push_job_i,
  input  logic            pop_i,
  output logic [JobW-1:0] head_job_o,
  output q_stat_t         q_stat_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [JobW-1:0] mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign q_stat_o.full  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign q_stat_o.empty = (cnt_q == '0);
  assign do_push        = push_i & ~q_stat_o.full;
  assign do_pop         = pop_i & ~q_stat_o.empty;
  assign head_job_o     = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

@@ rtl/pau3x_back.sv @@
// Back end: builds the 3x3 block from a job and holds it in the output register.
module pau3x_back import pau3x_pkg::*; #(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEFAULT,
  localparam int unsigned JobW      = 5 * PIXEL_BITS + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  q_stat_t         q_stat_i,
  input  logic [JobW-1:0] head_job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_beat_t       out_o
);

  localparam int unsigned PB = PIXEL_BITS;

  logic [PB-1:0] pb, pe, ph, pd, pf;
  logic          last;
  logic          valid_q;
  out_beat_t     out_q, out_d;

  function automatic logic [PB-1:0] corner(logic [PB-1:0] near, logic [PB-1:0] far,
                                           logic [PB-1:0] side, logic [PB-1:0] other,
                                           logic [PB-1:0] e);
    return (side == near && far != near && other != near) ? near : e;
  endfunction

  assign {last, pf, pd, ph, pe, pb} = head_job_i;

  assign pop_o = ~q_stat_i.empty & (~valid_q | ~out_stall_i);

  always_comb begin
    out_d.top_left    = PORT_PIX_W'(corner(pb, ph, pd, pf, pe));
    out_d.top_mid     = PORT_PIX_W'(pe);
    out_d.top_right   = PORT_PIX_W'(corner(pb, ph, pf, pd, pe));
    out_d.mid_left    = PORT_PIX_W'(pe);
    out_d.mid_mid     = PORT_PIX_W'(pe);
    out_d.mid_right   = PORT_PIX_W'(pe);
    out_d.bot_left    = PORT_PIX_W'(corner(ph, pb, pd, pf, pe));
    out_d.bot_mid     = PORT_PIX_W'(pe);
    out_d.bot_right   = PORT_PIX_W'(corner(ph, pb, pf, pd, pe));
    out_d.last_of_row = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || !out_stall_i) begin
      valid_q <= ~q_stat_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = out_q;

endmodule
